// ----- sv/csft_pkg.sv -----
// shared types and constants of the case-folded string table
package csft_pkg;

    // default geometry
    localparam int ENTRIES_DEF = 64;
    localparam int STRLEN_DEF  = 32;

    // widest slot index and byte position that the control struct carries
    localparam int SLOT_W_MAX = 10;
    localparam int POS_W_MAX  = 6;

    // input commands
    localparam logic [1:0] CMD_STORE_FOLD = 2'd0;
    localparam logic [1:0] CMD_STORE_RAW  = 2'd1;
    localparam logic [1:0] CMD_QUERY      = 2'd2;
    localparam logic [1:0] CMD_SWAP       = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_STORE  = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_SWAP   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_DELIM   = 2'd0;
    localparam logic [1:0] REG_WS_STOP = 2'd1;
    localparam logic [1:0] REG_IN_USE  = 2'd2;

    // case fold mask and whitespace bound
    localparam logic [7:0] FOLD_MASK = 8'h20;
    localparam logic [7:0] WS_LIMIT  = 8'd33;

    // match bit operations of a cell
    localparam logic [2:0] OP_HOLD   = 3'd0;
    localparam logic [2:0] OP_NARROW = 3'd1;
    localparam logic [2:0] OP_ENDKEY = 3'd2;
    localparam logic [2:0] OP_SHIFT  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    // control broadcast to every cell
    typedef struct packed {
        logic                  wa_en;
        logic [SLOT_W_MAX-1:0] wa_slot;
        logic [7:0]            wa_data;
        logic                  wb_en;
        logic [SLOT_W_MAX-1:0] wb_slot;
        logic [7:0]            wb_data;
        logic [POS_W_MAX-1:0]  waddr;
        logic [POS_W_MAX-1:0]  raddr;
        logic [7:0]            key;
        logic [2:0]            op;
    } t_cell_ctl;

endpackage

// ----- sv/case_folded_string_table_core.sv -----
// top level of the case-folded string table: control sequencer and row of slot cells
//
// channel   direction  handshake                   payload
// input     in         i_in_valid / o_in_stall     i_cmd i_slot i_other_slot i_char_in
// result    out        o_out_valid / i_out_stall   o_done_kind o_stored_length o_found
//                                                  o_match_slot o_key_overflow
// config    in         i_cfg_we                    i_cfg_index i_cfg_data
//
// a store character is written in the idle state, a query character passes ST_QCMP (registered cell read)
// a delimiter passes ST_LEND, then ST_LSCAN goes over the slots until a match or entries_in_use (at most ENTRIES)
// a swap runs through ST_SWAP and ST_SDONE, one byte column copied per cycle
// reset is synchronous and active low; slot bytes are not cleared
// a result still waiting under i_out_stall stalls the input
module case_folded_string_table_core #(
    parameter int ENTRIES = csft_pkg::ENTRIES_DEF,
    parameter int STRLEN  = csft_pkg::STRLEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_cmd,
    input  logic [5:0] i_slot,
    input  logic [5:0] i_other_slot,
    input  logic [7:0] i_char_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_done_kind,
    output logic [4:0] o_stored_length,
    output logic       o_found,
    output logic [5:0] o_match_slot,
    output logic       o_key_overflow,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    localparam int SW = $clog2(ENTRIES);
    localparam int PW = $clog2(STRLEN);
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_QCMP  = 3'd1;
    localparam logic [2:0] ST_LEND  = 3'd2;
    localparam logic [2:0] ST_LSCAN = 3'd3;
    localparam logic [2:0] ST_SWAP  = 3'd4;
    localparam logic [2:0] ST_SDONE = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_pos, n_pos;
    logic          r_key_over, n_key_over;
    logic [7:0]    r_key, n_key;
    logic [SW-1:0] r_s1, n_s1, r_s2, n_s2;
    logic [PW:0]   r_sp, n_sp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_delim;
    logic          r_ws_stop;
    logic [6:0]    r_in_use;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_kind, n_kind;
    logic [4:0]    r_len, n_len;
    logic          r_found, n_found;
    logic [5:0]    r_mslot, n_mslot;
    logic          r_kover, n_kover;

    csft_pkg::t_cell_ctl w_ctl;
    logic [SW-1:0] w_mod_tab [64];
    logic [7:0]    w_rd [ENTRIES];
    logic          w_match [ENTRIES+1];
    logic          w_free, w_acc, w_term, w_scan_end;
    logic [SW-1:0] w_slot, w_oslot;
    logic [CW-1:0] w_lim;

    // slot index reduction table, built at elaboration
    for (genvar k = 0; k < 64; k++) begin : g_mod
        assign w_mod_tab[k] = SW'(k % ENTRIES);
    end
    assign w_slot  = w_mod_tab[i_slot];
    assign w_oslot = w_mod_tab[i_other_slot];

    // row of slot cells, match bits chained toward slot zero
    assign w_match[ENTRIES] = 1'b0;
    for (genvar e = 0; e < ENTRIES; e++) begin : g_cell
        csft_cell #(.STRLEN(STRLEN), .IDX(e)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_next_match (w_match[e+1]),
            .o_match      (w_match[e]),
            .o_rd         (w_rd[e])
        );
    end

    // handshake
    assign w_free     = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == ST_IDLE) && w_free);
    assign w_acc      = i_in_valid && !o_in_stall;

    // store terminator
    assign w_term = (i_char_in == 8'd0) || (i_char_in == r_delim) ||
                    ((i_cmd == csft_pkg::CMD_STORE_FOLD) && r_ws_stop &&
                     ((i_char_in < csft_pkg::WS_LIMIT) || i_char_in[7]));

    // search limit and end of scan
    assign w_lim      = (32'(r_in_use) > 32'(ENTRIES)) ? CW'(ENTRIES) : CW'(r_in_use);
    assign w_scan_end = r_key_over || (r_cnt == w_lim);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_key_over  = r_key_over;
        n_key       = r_key;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_sp        = r_sp;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_len       = r_len;
        n_found     = r_found;
        n_mslot     = r_mslot;
        n_kover     = r_kover;

        w_ctl         = '0;
        w_ctl.op      = csft_pkg::OP_HOLD;
        w_ctl.key     = r_key;
        w_ctl.raddr   = csft_pkg::POS_W_MAX'(r_pos);
        w_ctl.waddr   = csft_pkg::POS_W_MAX'(r_pos);

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_cmd)
                        csft_pkg::CMD_STORE_FOLD, csft_pkg::CMD_STORE_RAW: begin
                            w_ctl.wa_en   = 1'b1;
                            w_ctl.wa_slot = csft_pkg::SLOT_W_MAX'(w_slot);
                            if (w_term || r_pos == PW'(STRLEN - 1)) begin
                                w_ctl.wa_data = 8'd0;
                                n_out_valid   = 1'b1;
                                n_kind        = csft_pkg::KIND_STORE;
                                n_len         = 5'(r_pos);
                                n_found       = 1'b0;
                                n_mslot       = 6'd0;
                                n_kover       = 1'b0;
                                n_pos         = '0;
                            end else begin
                                w_ctl.wa_data = (i_cmd == csft_pkg::CMD_STORE_FOLD) ?
                                                (i_char_in | csft_pkg::FOLD_MASK) : i_char_in;
                                n_pos         = r_pos + PW'(1);
                            end
                        end
                        csft_pkg::CMD_QUERY: begin
                            if (i_char_in == r_delim) begin
                                n_cnt   = '0;
                                n_state = ST_LEND;
                            end else if (r_pos == PW'(STRLEN - 1)) begin
                                n_key_over = 1'b1;
                            end else begin
                                n_key   = i_char_in;
                                n_state = ST_QCMP;
                            end
                        end
                        default: begin
                            if (w_slot == w_oslot) begin
                                n_out_valid = 1'b1;
                                n_kind      = csft_pkg::KIND_SWAP;
                                n_len       = 5'd0;
                                n_found     = 1'b0;
                                n_mslot     = 6'd0;
                                n_kover     = 1'b0;
                            end else begin
                                n_s1    = w_slot;
                                n_s2    = w_oslot;
                                n_sp    = '0;
                                n_state = ST_SWAP;
                            end
                        end
                    endcase
                end
            end
            ST_QCMP: begin
                w_ctl.op = csft_pkg::OP_NARROW;
                n_pos    = r_pos + PW'(1);
                n_state  = ST_IDLE;
            end
            ST_LEND: begin
                w_ctl.op = csft_pkg::OP_ENDKEY;
                n_state  = ST_LSCAN;
            end
            ST_LSCAN: begin
                if (w_scan_end || w_match[0]) begin
                    if (w_free) begin
                        w_ctl.op    = csft_pkg::OP_CLEAR;
                        n_out_valid = 1'b1;
                        n_kind      = csft_pkg::KIND_LOOKUP;
                        n_len       = 5'd0;
                        n_found     = !w_scan_end;
                        n_mslot     = w_scan_end ? 6'd0 : 6'(r_cnt);
                        n_kover     = r_key_over;
                        n_key_over  = 1'b0;
                        n_pos       = '0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    w_ctl.op = csft_pkg::OP_SHIFT;
                    n_cnt    = r_cnt + CW'(1);
                end
            end
            ST_SWAP: begin
                // read column r_sp, write column r_sp-1 crosswise
                w_ctl.raddr = csft_pkg::POS_W_MAX'(r_sp[PW-1:0]);
                if (r_sp != '0) begin
                    w_ctl.waddr   = csft_pkg::POS_W_MAX'(r_sp[PW-1:0] - PW'(1));
                    w_ctl.wa_en   = 1'b1;
                    w_ctl.wa_slot = csft_pkg::SLOT_W_MAX'(r_s1);
                    w_ctl.wa_data = w_rd[r_s2];
                    w_ctl.wb_en   = 1'b1;
                    w_ctl.wb_slot = csft_pkg::SLOT_W_MAX'(r_s2);
                    w_ctl.wb_data = w_rd[r_s1];
                end
                n_sp = r_sp + (PW+1)'(1);
                if (r_sp == (PW+1)'(STRLEN)) begin
                    n_state = ST_SDONE;
                end
            end
            ST_SDONE: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_kind      = csft_pkg::KIND_SWAP;
                    n_len       = 5'd0;
                    n_found     = 1'b0;
                    n_mslot     = 6'd0;
                    n_kover     = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_key_over  <= 1'b0;
            r_out_valid <= 1'b0;
            r_delim     <= 8'd0;
            r_ws_stop   <= 1'b0;
            r_in_use    <= 7'd0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_key_over  <= n_key_over;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    csft_pkg::REG_DELIM:   r_delim   <= i_cfg_data;
                    csft_pkg::REG_WS_STOP: r_ws_stop <= i_cfg_data[0];
                    csft_pkg::REG_IN_USE:  r_in_use  <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_s1    <= n_s1;
        r_s2    <= n_s2;
        r_sp    <= n_sp;
        r_cnt   <= n_cnt;
        r_kind  <= n_kind;
        r_len   <= n_len;
        r_found <= n_found;
        r_mslot <= n_mslot;
        r_kover <= n_kover;
    end

    assign o_out_valid     = r_out_valid;
    assign o_done_kind     = r_kind;
    assign o_stored_length = r_len;
    assign o_found         = r_found;
    assign o_match_slot    = r_mslot;
    assign o_key_overflow  = r_kover;

`ifndef ASSERT_OFF
    // items are only taken by the idle sequencer
    a_acc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |-> r_state == ST_IDLE) else $error("item accepted while busy");

    // character position never passes the last byte of a slot
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) <= STRLEN - 1) else $error("character position out of range");

    // a found lookup never carries the overflow flag
    a_found_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_done_kind == csft_pkg::KIND_LOOKUP && !o_key_overflow))
        else $error("found set on a wrong result");

    // a swap copy runs on until it completes
    a_swap_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWAP |=> (r_state == ST_SWAP || r_state == ST_SDONE))
        else $error("swap copy interrupted");
`endif
endmodule

// ----- sv/csft_cell.sv -----
// one name slot: byte memory, registered read and match bit
module csft_cell #(
    parameter int STRLEN  = csft_pkg::STRLEN_DEF,
    parameter int IDX     = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csft_pkg::t_cell_ctl i_ctl,
    input  logic                i_next_match,
    output logic                o_match,
    output logic [7:0]          o_rd
);
    localparam int PW = $clog2(STRLEN);

    logic [7:0] mem [STRLEN];
    logic [7:0] r_rd;
    logic       r_match;
    logic       w_eq;

    // slot bytes, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wa_en && i_ctl.wa_slot == csft_pkg::SLOT_W_MAX'(IDX)) begin
            mem[i_ctl.waddr[PW-1:0]] <= i_ctl.wa_data;
        end else if (i_ctl.wb_en && i_ctl.wb_slot == csft_pkg::SLOT_W_MAX'(IDX)) begin
            mem[i_ctl.waddr[PW-1:0]] <= i_ctl.wb_data;
        end
        r_rd <= mem[i_ctl.raddr[PW-1:0]];
    end

    // folded compare of the stored byte with the key byte
    assign w_eq = (r_rd != 8'd0) &&
                  ((r_rd | csft_pkg::FOLD_MASK) == (i_ctl.key | csft_pkg::FOLD_MASK));

    // match bit, shifted toward slot zero during the search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
        end else begin
            case (i_ctl.op)
                csft_pkg::OP_NARROW: r_match <= r_match & w_eq;
                csft_pkg::OP_ENDKEY: r_match <= r_match & (r_rd == 8'd0);
                csft_pkg::OP_SHIFT:  r_match <= i_next_match;
                csft_pkg::OP_CLEAR:  r_match <= 1'b1;
                default:             r_match <= r_match;
            endcase
        end
    end

    assign o_match = r_match;
    assign o_rd    = r_rd;
endmodule
